// File: sv/dno_pkg.sv
// Shared types and constant tables for the note oscillator.
`timescale 1ns / 1ps
package dno_pkg;

	// Input item kinds
	localparam logic FUNC_TICK = 1'b0;
	localparam logic FUNC_NOTE = 1'b1;

	// Configuration register indexes
	localparam logic REG_WAVE_SHAPE = 1'b0;
	localparam logic REG_VOLUME     = 1'b1;

	localparam int DATA_W     = 4;
	localparam int SAMPLE_W   = 10;
	localparam int STEP_SLOTS = 16;
	localparam int SINE_STORED = 128;

	typedef enum logic [1:0] {
		WAVE_SAW      = 2'd0,
		WAVE_SQUARE   = 2'd1,
		WAVE_TRIANGLE = 2'd2,
		WAVE_SINE     = 2'd3
	} wave_t;

	typedef struct packed {
		logic       func;
		logic       note_press;
		logic [2:0] octave_number;
		logic [3:0] note_index;
	} item_t;

	// Phase steps for octave 4, C through B; unused slots give no pitch
	localparam logic [31:0] STEP_TABLE [STEP_SLOTS] = '{
		32'd51076056, 32'd54113197, 32'd57330935, 32'd60740010,
		32'd64351798, 32'd68178356, 32'd72232452, 32'd76527617,
		32'd81078186, 32'd85899345, 32'd91007186, 32'd96418755,
		32'd0, 32'd0, 32'd0, 32'd0
	};

	// Rising half of the sine, offset so that 128 is the midpoint
	localparam logic [7:0] SINE_HALF [SINE_STORED] = '{
		8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1,   8'd1,   8'd2,
		8'd2,   8'd3,   8'd4,   8'd5,   8'd5,   8'd6,   8'd7,   8'd9,
		8'd10,  8'd11,  8'd12,  8'd14,  8'd15,  8'd17,  8'd18,  8'd20,
		8'd21,  8'd23,  8'd25,  8'd27,  8'd29,  8'd31,  8'd33,  8'd35,
		8'd37,  8'd40,  8'd42,  8'd44,  8'd47,  8'd49,  8'd52,  8'd54,
		8'd57,  8'd59,  8'd62,  8'd65,  8'd67,  8'd70,  8'd73,  8'd76,
		8'd79,  8'd82,  8'd85,  8'd88,  8'd90,  8'd93,  8'd97,  8'd100,
		8'd103, 8'd106, 8'd109, 8'd112, 8'd115, 8'd118, 8'd121, 8'd124,
		8'd128, 8'd131, 8'd134, 8'd137, 8'd140, 8'd143, 8'd146, 8'd149,
		8'd152, 8'd155, 8'd158, 8'd162, 8'd165, 8'd167, 8'd170, 8'd173,
		8'd176, 8'd179, 8'd182, 8'd185, 8'd188, 8'd190, 8'd193, 8'd196,
		8'd198, 8'd201, 8'd203, 8'd206, 8'd208, 8'd211, 8'd213, 8'd215,
		8'd218, 8'd220, 8'd222, 8'd224, 8'd226, 8'd228, 8'd230, 8'd232,
		8'd234, 8'd235, 8'd237, 8'd238, 8'd240, 8'd241, 8'd243, 8'd244,
		8'd245, 8'd246, 8'd248, 8'd249, 8'd250, 8'd250, 8'd251, 8'd252,
		8'd253, 8'd253, 8'd254, 8'd254, 8'd254, 8'd255, 8'd255, 8'd255
	};

endpackage

// File: sv/dno_phase.sv
// Phase step selection and 32-bit phase accumulator.
`timescale 1ns / 1ps
module dno_phase #(
	parameter int NOTE_COUNT = 12
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  dno_pkg::item_t      item,
	output logic [8:0]          phase_top
);

	logic [31:0] acc_q;
	logic [31:0] step_q;
	logic [31:0] acc_sum;
	logic [31:0] base;
	logic [31:0] new_step;
	logic        note_ok;

	assign acc_sum   = acc_q + step_q;
	assign phase_top = acc_sum[31:23];

	assign base    = dno_pkg::STEP_TABLE[item.note_index];
	assign note_ok = item.note_press && ({1'b0, item.note_index} < 5'(NOTE_COUNT));

	always_comb begin
		if (!note_ok) begin
			new_step = '0;
		end else if (item.octave_number[2]) begin
			new_step = base << item.octave_number[1:0];
		end else begin
			new_step = base >> (3'd4 - item.octave_number);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			step_q <= '0;
		end else if (en) begin
			if (item.func == dno_pkg::FUNC_NOTE) begin
				step_q <= new_step;
			end else begin
				acc_q <= acc_sum;
			end
		end
	end

endmodule

// File: sv/dno_wave.sv
// Waveform shaper: top phase bits to attenuated, offset sample.
`timescale 1ns / 1ps
module dno_wave #(
	parameter int SINE_ENTRIES = 128
) (
	input  logic [8:0]                          phase_top,
	input  dno_pkg::wave_t                      shape,
	input  logic [3:0]                          volume,
	output logic signed [dno_pkg::SAMPLE_W-1:0] sample
);

	localparam int SineLimit = (SINE_ENTRIES < dno_pkg::SINE_STORED) ?
		SINE_ENTRIES : dno_pkg::SINE_STORED;

	logic [7:0]                          top;
	logic [7:0]                          mirror;
	logic [6:0]                          idx;
	logic [3:0]                          shamt;
	logic signed [dno_pkg::SAMPLE_W-1:0] raw;
	logic signed [dno_pkg::SAMPLE_W-1:0] scaled;

	assign top    = phase_top[8:1];
	assign mirror = 8'd255 - top;

	always_comb begin
		idx = top[7] ? mirror[6:0] : top[6:0];
		if ({1'b0, idx} >= 8'(SineLimit)) begin
			idx = 7'(SineLimit - 1);
		end
	end

	always_comb begin
		case (shape)
			dno_pkg::WAVE_SAW: begin
				raw = $signed({2'b00, top}) - 10'sd128;
			end
			dno_pkg::WAVE_SQUARE: begin
				raw = (top > 8'd128) ? -10'sd128 : 10'sd127;
			end
			dno_pkg::WAVE_TRIANGLE: begin
				// falling half uses the mirrored byte, rising half keeps one extra phase bit
				if (top[7]) begin
					raw = $signed({1'b0, mirror[6:0], 2'b00}) - 10'sd254;
				end else begin
					raw = $signed({1'b0, top[6:0], phase_top[0], 1'b0}) - 10'sd256;
				end
			end
			dno_pkg::WAVE_SINE: begin
				raw = $signed({2'b00, dno_pkg::SINE_HALF[idx]}) - 10'sd128;
			end
			default: begin
				raw = '0;
			end
		endcase
	end

	// volume of eight or above means full level
	assign shamt  = (volume > 4'd8) ? 4'd0 : 4'd8 - volume;
	assign scaled = raw >>> shamt;
	assign sample = scaled + 10'sd128;

endmodule

// File: sv/dds_note_oscillator.sv
// Top level of the note oscillator: handshakes, configuration, stage and result registers.
// A tick item is registered in the input stage, then its sample in the result register behind out_valid.
// Throughput: one item per cycle unless a tick is held by a stalled result; note items take a slot but give no sample.
// Notes always leave the input stage; ticks do while the result register is free or being taken.
// Reset clears phase, step, wave shape (sawtooth) and volume (zero), and empties both stages.
`timescale 1ns / 1ps
module dds_note_oscillator #(
	parameter int SINE_ENTRIES = 128,
	parameter int NOTE_COUNT   = 12
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                func,
	input  logic                                note_press,
	input  logic [2:0]                          octave_number,
	input  logic [3:0]                          note_index,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [dno_pkg::SAMPLE_W-1:0] sample_value,
	input  logic                                wr_en,
	input  logic                                wr_index,
	input  logic [dno_pkg::DATA_W-1:0]          wr_data
);

	dno_pkg::item_t                      item_s1;
	logic                                valid_s1;
	logic                                out_valid_q;
	logic signed [dno_pkg::SAMPLE_W-1:0] sample_q;
	dno_pkg::wave_t                      wave_shape_q;
	logic [3:0]                          volume_level_q;

	logic                                out_free;
	logic                                adv_s1;
	logic                                tick_adv;
	logic                                in_fire;
	logic [8:0]                          phase_top;
	logic signed [dno_pkg::SAMPLE_W-1:0] sample_next;

	assign out_free = !out_valid_q || out_ready;
	assign adv_s1   = valid_s1 && (item_s1.func == dno_pkg::FUNC_NOTE || out_free);
	assign tick_adv = adv_s1 && item_s1.func == dno_pkg::FUNC_TICK;
	assign in_ready = !valid_s1 || adv_s1;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_shape_q   <= dno_pkg::WAVE_SAW;
			volume_level_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				dno_pkg::REG_WAVE_SHAPE: wave_shape_q <= dno_pkg::wave_t'(wr_data[1:0]);
				dno_pkg::REG_VOLUME:     volume_level_q <= wr_data[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1.func          <= func;
			item_s1.note_press    <= note_press;
			item_s1.octave_number <= octave_number;
			item_s1.note_index    <= note_index;
		end
	end

	dno_phase #(
		.NOTE_COUNT(NOTE_COUNT)
	) u_phase (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv_s1),
		.item     (item_s1),
		.phase_top(phase_top)
	);

	dno_wave #(
		.SINE_ENTRIES(SINE_ENTRIES)
	) u_wave (
		.phase_top(phase_top),
		.shape    (wave_shape_q),
		.volume   (volume_level_q),
		.sample   (sample_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (tick_adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_adv) begin
			sample_q <= sample_next;
		end
	end

	assign out_valid    = out_valid_q;
	assign sample_value = sample_q;

`ifndef ASSERT_OFF
	// an empty stage must always take an item
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input stage empty but not ready");

	// a tick blocked by a held result must stay put
	a_tick_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && item_s1.func == dno_pkg::FUNC_TICK && out_valid_q && !out_ready
		|=> valid_s1 && $stable(item_s1) && out_valid_q)
		else $error("tick item lost while result stalled");

	// only a tick may produce a result
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_free && !tick_adv |=> !out_valid_q)
		else $error("result produced without a tick item");
`endif

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the note oscillator: directed script, then random phases.
`timescale 1ns / 1ps
module testbench;

	localparam logic KEY_RELEASE = 1'b0;
	localparam logic KEY_PRESS   = 1'b1;
	localparam int   NOTES       = 12;
	localparam int   SETTLE_CYCLES = 4;	// a note item lands in the step register once the input stage passes it on
	localparam int   PHASES      = 7;
	localparam int   PHASE_ITEMS = 250;
	localparam int   ROWS        = 30;

	typedef enum logic {ROW_WRITE, ROW_ITEM} row_kind_t;

	typedef struct {
		row_kind_t                           kind;
		logic                                reg_idx;
		logic [dno_pkg::DATA_W-1:0]          reg_data;
		logic                                f;
		logic                                press;
		logic [2:0]                          oct;
		logic [3:0]                          note;
		bit                                  typed;
		logic signed [dno_pkg::SAMPLE_W-1:0] want;
	} script_row_t;

	// Typed samples: phase stays at zero until the first press
	script_row_t script [ROWS] = '{
		'{ROW_ITEM,  dno_pkg::REG_WAVE_SHAPE, 4'd0, dno_pkg::FUNC_TICK, KEY_RELEASE,
			3'd0, 4'd0, 1'b1, 10'sd127},
		'{ROW_WRITE, dno_pkg::REG_VOLUME, 4'd8, dno_pkg::FUNC_TICK, KEY_RELEASE,
			3'd0, 4'd0, 1'b0, '0},
		'{ROW_ITEM,  dno_pkg::REG_WAVE_SHAPE, 4'd0, dno_pkg::FUNC_TICK, KEY_RELEASE,
			3'd0, 4'd0, 1'b1, 10'sd0},
		'{ROW_WRITE, dno_pkg::REG_WAVE_SHAPE, 4'(dno_pkg::WAVE_SQUARE), dno_pkg::FUNC_TICK,
			KEY_RELEASE, 3'd0, 4'd0, 1'b0, '0},
		'{ROW_ITEM,  dno_pkg::REG_WAVE_SHAPE, 4'd0, dno_pkg::FUNC_TICK, KEY_RELEASE,
			3'd0, 4'd0, 1'b1, 10'sd255},
		'{ROW_WRITE, dno_pkg::REG_WAVE_SHAPE, 4'(dno_pkg::WAVE_TRIANGLE), dno_pkg::FUNC_TICK,
			KEY_RELEASE, 3'd0, 4'd0, 1'b0, '0},
		'{ROW_ITEM,  dno_pkg::REG_WAVE_SHAPE, 4'd0, dno_pkg::FUNC_TICK, KEY_RELEASE,
			3'd0, 4'd0, 1'b1, -10'sd128},
		'{ROW_WRITE, dno_pkg::REG_WAVE_SHAPE, 4'(dno_pkg::WAVE_SINE), dno_pkg::FUNC_TICK,
			KEY_RELEASE, 3'd0, 4'd0, 1'b0, '0},
		'{ROW_ITEM,  dno_pkg::REG_WAVE_SHAPE, 4'd0, dno_pkg::FUNC_TICK, KEY_RELEASE,
			3'd0, 4'd0, 1'b1, 10'sd0},
		'{ROW_WRITE, dno_pkg::REG_VOLUME, 4'd15, dno_pkg::FUNC_TICK, KEY_RELEASE,
			3'd0, 4'd0, 1'b0, '0},
		'{ROW_ITEM,  dno_pkg::REG_WAVE_SHAPE, 4'd0, dno_pkg::FUNC_TICK, KEY_RELEASE,
			3'd0, 4'd0, 1'b1, 10'sd0},
		'{ROW_ITEM,  dno_pkg::REG_WAVE_SHAPE, 4'd0, dno_pkg::FUNC_NOTE, KEY_PRESS,
			3'd7, 4'd11, 1'b0, '0},
		'{ROW_ITEM,  dno_pkg::REG_WAVE_SHAPE, 4'd0, dno_pkg::FUNC_TICK, KEY_RELEASE,
			3'd0, 4'd0, 1'b0, '0},
		'{ROW_ITEM,  dno_pkg::REG_WAVE_SHAPE, 4'd0, dno_pkg::FUNC_TICK, KEY_PRESS,
			3'd7, 4'd15, 1'b0, '0},
		'{ROW_ITEM,  dno_pkg::REG_WAVE_SHAPE, 4'd0, dno_pkg::FUNC_NOTE, KEY_PRESS,
			3'd0, 4'd0, 1'b0, '0},
		'{ROW_ITEM,  dno_pkg::REG_WAVE_SHAPE, 4'd0, dno_pkg::FUNC_TICK, KEY_RELEASE,
			3'd0, 4'd0, 1'b0, '0},
		// note past the table and an unused slot both silence the voice
		'{ROW_ITEM,  dno_pkg::REG_WAVE_SHAPE, 4'd0, dno_pkg::FUNC_NOTE, KEY_PRESS,
			3'd4, 4'd12, 1'b0, '0},
		'{ROW_ITEM,  dno_pkg::REG_WAVE_SHAPE, 4'd0, dno_pkg::FUNC_TICK, KEY_RELEASE,
			3'd0, 4'd0, 1'b0, '0},
		'{ROW_ITEM,  dno_pkg::REG_WAVE_SHAPE, 4'd0, dno_pkg::FUNC_NOTE, KEY_PRESS,
			3'd7, 4'd15, 1'b0, '0},
		'{ROW_ITEM,  dno_pkg::REG_WAVE_SHAPE, 4'd0, dno_pkg::FUNC_TICK, KEY_RELEASE,
			3'd0, 4'd0, 1'b0, '0},
		'{ROW_ITEM,  dno_pkg::REG_WAVE_SHAPE, 4'd0, dno_pkg::FUNC_NOTE, KEY_RELEASE,
			3'd3, 4'd5, 1'b0, '0},
		'{ROW_ITEM,  dno_pkg::REG_WAVE_SHAPE, 4'd0, dno_pkg::FUNC_TICK, KEY_RELEASE,
			3'd0, 4'd0, 1'b0, '0},
		'{ROW_WRITE, dno_pkg::REG_WAVE_SHAPE, 4'(dno_pkg::WAVE_SAW), dno_pkg::FUNC_TICK,
			KEY_RELEASE, 3'd0, 4'd0, 1'b0, '0},
		'{ROW_WRITE, dno_pkg::REG_VOLUME, 4'd0, dno_pkg::FUNC_TICK, KEY_RELEASE,
			3'd0, 4'd0, 1'b0, '0},
		'{ROW_ITEM,  dno_pkg::REG_WAVE_SHAPE, 4'd0, dno_pkg::FUNC_NOTE, KEY_PRESS,
			3'd4, 4'd9, 1'b0, '0},
		'{ROW_ITEM,  dno_pkg::REG_WAVE_SHAPE, 4'd0, dno_pkg::FUNC_TICK, KEY_RELEASE,
			3'd0, 4'd0, 1'b0, '0},
		'{ROW_ITEM,  dno_pkg::REG_WAVE_SHAPE, 4'd0, dno_pkg::FUNC_TICK, KEY_RELEASE,
			3'd0, 4'd0, 1'b0, '0},
		'{ROW_WRITE, dno_pkg::REG_VOLUME, 4'd4, dno_pkg::FUNC_TICK, KEY_RELEASE,
			3'd0, 4'd0, 1'b0, '0},
		'{ROW_ITEM,  dno_pkg::REG_WAVE_SHAPE, 4'd0, dno_pkg::FUNC_TICK, KEY_RELEASE,
			3'd0, 4'd0, 1'b0, '0},
		'{ROW_ITEM,  dno_pkg::REG_WAVE_SHAPE, 4'd0, dno_pkg::FUNC_TICK, KEY_RELEASE,
			3'd0, 4'd0, 1'b0, '0}
	};

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                in_valid = 1'b0;
	logic                                in_ready;
	logic                                func = dno_pkg::FUNC_TICK;
	logic                                note_press = KEY_RELEASE;
	logic [2:0]                          octave_number = '0;
	logic [3:0]                          note_index = '0;
	logic                                out_valid;
	logic                                out_ready = 1'b0;
	logic signed [dno_pkg::SAMPLE_W-1:0] sample_value;
	logic                                wr_en = 1'b0;
	logic                                wr_index = dno_pkg::REG_WAVE_SHAPE;
	logic [dno_pkg::DATA_W-1:0]          wr_data = '0;

	// mirror of the voice
	logic [31:0]    phase_acc = '0;
	logic [31:0]    phase_inc = '0;
	dno_pkg::wave_t shape_m = dno_pkg::WAVE_SAW;
	logic [3:0]     vol_m = '0;

	logic signed [dno_pkg::SAMPLE_W-1:0] sample_q [$];
	bit                                  typed_now = 1'b0;
	logic signed [dno_pkg::SAMPLE_W-1:0] want_now = '0;
	bit                                  calm = 1'b0;
	int                                  errors = 0;

	dds_note_oscillator u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.func          (func),
		.note_press    (note_press),
		.octave_number (octave_number),
		.note_index    (note_index),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.sample_value  (sample_value),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data)
	);

	always #4 clk = ~clk;

	initial begin
		#8_000_000;
		$display("testbench: errors");
		$finish;
	end

	function automatic logic signed [dno_pkg::SAMPLE_W-1:0] advance_phase_sample();
		logic [7:0] top;
		int         v;
		int         idx;
		int         sh;
		phase_acc = phase_acc + phase_inc;
		top = phase_acc[31:24];
		case (shape_m)
			dno_pkg::WAVE_SAW:    v = int'(top) - 128;
			dno_pkg::WAVE_SQUARE: v = (top > 8'd128) ? -128 : 127;
			dno_pkg::WAVE_TRIANGLE: begin
				if (top >= 8'd128)
					v = 2 * (int'(8'd255 - top) * 2 - 127);
				else
					v = 2 * (int'(phase_acc[31:23]) - 128);
			end
			default: begin
				// falling half reads the table backward; index stays below 128
				idx = (top >= 8'd128) ? int'(8'd255 - top) : int'(top);
				v = int'(dno_pkg::SINE_HALF[idx]) - 128;
			end
		endcase
		sh = 8 - ((vol_m > 4'd8) ? 8 : int'(vol_m));
		v = (v >>> sh) + 128;
		return v[dno_pkg::SAMPLE_W-1:0];
	endfunction

	function automatic void apply_note(logic press, logic [2:0] oct, logic [3:0] note);
		logic [31:0] base;
		if (press == KEY_PRESS && note < NOTES) begin
			base = dno_pkg::STEP_TABLE[note];
			phase_inc = (oct > 3'd3) ? base << (oct - 3'd4) : base >> (3'd4 - oct);
		end else
			phase_inc = '0;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	always @(posedge clk) begin : scoreboard
		logic signed [dno_pkg::SAMPLE_W-1:0] want;
		if (arst_n) begin
			if (wr_en) begin
				if (wr_index == dno_pkg::REG_WAVE_SHAPE)
					shape_m = dno_pkg::wave_t'(wr_data[1:0]);
				else
					vol_m = wr_data;
			end
			if (out_valid && out_ready) begin
				if (sample_q.size() == 0) begin
					$error("sample_value: none expected, got %0d", sample_value);
					errors++;
				end else begin
					want = sample_q.pop_front();
					if (sample_value !== want) begin
						$error("sample_value: expected %0d, got %0d", want, sample_value);
						errors++;
					end
				end
			end
			if (in_valid && in_ready) begin
				if (func == dno_pkg::FUNC_NOTE)
					apply_note(note_press, octave_number, note_index);
				else begin
					want = advance_phase_sample();
					sample_q.push_back(typed_now ? want_now : want);
				end
			end
		end
	end

	// receiver: stalls of random length, none in calm phases
	initial begin : sink
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (calm)
				out_ready = 1'b1;
			else if ($urandom_range(0, 9) < 3) begin
				out_ready = 1'b0;
				repeat (pick_gap()) @(negedge clk);
			end else begin
				out_ready = 1'b1;
				repeat ($urandom_range(0, 12)) @(negedge clk);
			end
		end
	end

	task automatic send(logic f, logic p, logic [2:0] o, logic [3:0] n, bit typed,
			logic signed [dno_pkg::SAMPLE_W-1:0] w);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		repeat (gap) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		func = f;
		note_press = p;
		octave_number = o;
		note_index = n;
		typed_now = typed;
		want_now = w;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// drain, then give an in-flight note item time to land
	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (sample_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [dno_pkg::DATA_W-1:0] d);
		wr_en = 1'b1;
		wr_index = idx;
		wr_data = d;
		@(negedge clk);
		wr_en = 1'b0;
	endtask

	task automatic random_item();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			// tick with junk in the note fields
			send(dno_pkg::FUNC_TICK, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
				4'($urandom_range(0, 15)), 1'b0, '0);
		else if (r < 92)
			send(dno_pkg::FUNC_NOTE, KEY_PRESS, 3'($urandom_range(0, 7)),
				4'($urandom_range(0, NOTES - 1)), 1'b0, '0);
		else if (r < 96)
			send(dno_pkg::FUNC_NOTE, KEY_PRESS, 3'($urandom_range(0, 7)),
				4'($urandom_range(NOTES, 15)), 1'b0, '0);
		else
			send(dno_pkg::FUNC_NOTE, KEY_RELEASE, 3'($urandom_range(0, 7)),
				4'($urandom_range(0, 15)), 1'b0, '0);
	endtask

	initial begin : stimulus
		dno_pkg::wave_t shp;
		logic [3:0]     vol;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		foreach (script[k]) begin
			if (script[k].kind == ROW_WRITE) begin
				settle();
				write_reg(script[k].reg_idx, script[k].reg_data);
			end else
				send(script[k].f, script[k].press, script[k].oct, script[k].note,
					script[k].typed, script[k].want);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			case (ph)
				0: begin shp = dno_pkg::WAVE_SAW;      vol = 4'd8;  end
				1: begin shp = dno_pkg::WAVE_SQUARE;   vol = 4'd0;  end
				2: begin shp = dno_pkg::WAVE_TRIANGLE; vol = 4'd8;  end
				3: begin shp = dno_pkg::WAVE_SINE;     vol = 4'd15; end
				default: begin
					shp = dno_pkg::wave_t'($urandom_range(0, 3));
					vol = 4'($urandom_range(0, 15));
				end
			endcase
			// upper data bits are don't-care for the shape register
			write_reg(dno_pkg::REG_WAVE_SHAPE, {2'($urandom_range(0, 3)), shp});
			write_reg(dno_pkg::REG_VOLUME, vol);
			calm = (ph == 2);
			repeat (PHASE_ITEMS) random_item();
		end

		calm = 1'b0;
		settle();
		if (errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

// File: filelist.f
sv/dno_pkg.sv
sv/dno_phase.sv
sv/dno_wave.sv
sv/dds_note_oscillator.sv
tb/sv/testbench.sv
